@@ rtl/lsw_pkg.sv @@
`timescale 1ns / 1ps

package lsw_pkg;

  localparam int BITS_PER_WORD = 8;

  // request kinds
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_CS    = 2'd1;
  localparam logic [1:0] REQ_A0    = 2'd2;
  localparam logic [1:0] REQ_RESET = 2'd3;

  // configuration register indexes
  localparam logic [7:0] CFG_SPI_MODE   = 8'd0;
  localparam logic [7:0] CFG_HALF_DELAY = 8'd1;

  // final sequencer steps
  localparam logic [4:0] STEP_WRITE_LAST_M0 = 5'(2 * BITS_PER_WORD);
  localparam logic [4:0] STEP_WRITE_LAST_M3 = 5'(2 * BITS_PER_WORD - 1);
  localparam logic [4:0] STEP_CS_LAST_M3    = 5'd1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic sck;
    logic mosi;
    logic cs_n;
    logic a0;
    logic reset_pin;
    logic last;
  } out_t;

  // classified request as held in the queue
  typedef struct packed {
    logic [1:0] kind;
    logic       on;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [1:0] count;
  } front_status_t;

  typedef struct packed {
    logic fire;
    logic pop;
  } back_status_t;

endpackage

@@ rtl/lsw_front.sv @@
`timescale 1ns / 1ps

module lsw_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lsw_pkg::in_t           in_data,
  input  logic                   pop,
  output logic                   head_valid,
  output lsw_pkg::cmd_t          head,
  output lsw_pkg::front_status_t status
);

  lsw_pkg::cmd_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  lsw_pkg::cmd_t cmd;

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != 2'd0);
  assign head       = entry[rd_ptr];
  assign status.count = count;

  // classify: keep the level flag so the back end needs no compare
  always_comb begin
    cmd.kind = in_data.req_type;
    cmd.on   = |in_data.value;
    cmd.data = in_data.value;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/lsw_back.sv @@
`timescale 1ns / 1ps

module lsw_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  spi_mode,
  input  logic [7:0]            half_delay,
  input  logic                  head_valid,
  input  lsw_pkg::cmd_t         head,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lsw_pkg::out_t         out_data,
  output lsw_pkg::back_status_t status
);

  logic       sck;
  logic       mosi;
  logic       cs_n;
  logic       a0;
  logic       reset_pin;
  logic [4:0] step;
  logic [7:0] gap;

  logic       sck_next;
  logic       mosi_next;
  logic       cs_n_next;
  logic       a0_next;
  logic       reset_pin_next;
  logic       is_last;
  logic [2:0] bit_idx;
  logic       fire;

  assign bit_idx = step[3:1];
  assign fire    = head_valid && (gap == 8'd0) && (!out_valid || !out_stall);
  assign status.fire = fire;
  assign status.pop  = fire && is_last;

  always_comb begin
    sck_next       = sck;
    mosi_next      = mosi;
    cs_n_next      = cs_n;
    a0_next        = a0;
    reset_pin_next = reset_pin;
    is_last        = 1'b1;
    unique case (head.kind)
      lsw_pkg::REQ_WRITE: begin
        is_last = spi_mode ? (step == lsw_pkg::STEP_WRITE_LAST_M3)
                           : (step == lsw_pkg::STEP_WRITE_LAST_M0);
        if (step == lsw_pkg::STEP_WRITE_LAST_M0) begin
          sck_next = 1'b0;
        end else if (!step[0]) begin
          // mode 0 leaves SCK alone for the first bit
          if (spi_mode || bit_idx != 3'd0) begin
            sck_next = 1'b0;
          end
          // MSB first
          mosi_next = head.data[~bit_idx];
        end else begin
          sck_next = 1'b1;
        end
      end
      lsw_pkg::REQ_CS: begin
        if (spi_mode) begin
          is_last = (step == lsw_pkg::STEP_CS_LAST_M3);
          if (step == 5'd0) begin
            if (head.on) sck_next = 1'b1;
            else         cs_n_next = 1'b1;
          end else begin
            if (head.on) cs_n_next = 1'b0;
            else         sck_next = 1'b0;
          end
        end else begin
          cs_n_next = !head.on;
        end
      end
      lsw_pkg::REQ_A0: begin
        a0_next = head.on;
      end
      default: begin
        reset_pin_next = head.on;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.sck       <= sck_next;
      out_data.mosi      <= mosi_next;
      out_data.cs_n      <= cs_n_next;
      out_data.a0        <= a0_next;
      out_data.reset_pin <= reset_pin_next;
      out_data.last      <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sck       <= 1'b0;
      mosi      <= 1'b0;
      cs_n      <= 1'b1;
      a0        <= 1'b0;
      reset_pin <= 1'b0;
      step      <= 5'd0;
      gap       <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        sck       <= sck_next;
        mosi      <= mosi_next;
        cs_n      <= cs_n_next;
        a0        <= a0_next;
        reset_pin <= reset_pin_next;
        step      <= is_last ? 5'd0 : step + 5'd1;
        // hold the snapshot for the extra clocks before the next one
        gap       <= half_delay;
        out_valid <= 1'b1;
      end else begin
        if (gap != 8'd0) begin
          gap <= gap - 8'd1;
        end
        if (out_valid && !out_stall) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/lcd_spi_write_master_top.sv @@
`timescale 1ns / 1ps
// Requests are registered into the queue; snapshots are registered from the queue head.
// Pacing: the back-end sequencer spaces snapshots by half_delay and waits on out_stall;
//   a byte write takes 17 snapshots in mode 0 and 16 in mode 3, a chip select in
//   mode 3 takes 2, every other request 1. A two-entry queue keeps intake running.
// Reset (rst, synchronous): CS high, all other pins low, queue empty, mode 0, no delay.

module lcd_spi_write_master_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  lsw_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lsw_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_index,
  input  logic [7:0]    cfg_data
);

  logic                   spi_mode;
  logic [7:0]             half_delay;
  logic                   head_valid;
  lsw_pkg::cmd_t          head;
  lsw_pkg::front_status_t f_status;
  lsw_pkg::back_status_t  b_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      spi_mode   <= 1'b0;
      half_delay <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsw_pkg::CFG_SPI_MODE:   spi_mode   <= cfg_data[0];
        lsw_pkg::CFG_HALF_DELAY: half_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  lsw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .pop        (b_status.pop),
    .head_valid (head_valid),
    .head       (head),
    .status     (f_status)
  );

  lsw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .spi_mode   (spi_mode),
    .half_delay (half_delay),
    .head_valid (head_valid),
    .head       (head),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .status     (b_status)
  );

  // the queue never overfills
  assert property (@(posedge clk) disable iff (rst) f_status.count != 2'd3)
    else $error("queue count out of range");

  // a sequencer step is only taken from a queued request
  assert property (@(posedge clk) disable iff (rst) b_status.fire |-> head_valid)
    else $error("sequencer fired with empty queue");

  // retiring a request presents its final snapshot next
  assert property (@(posedge clk) disable iff (rst)
    b_status.pop |=> out_valid && out_data.last)
    else $error("request retired without final snapshot");

  // snapshots are spaced by the hold delay
  assert property (@(posedge clk) disable iff (rst)
    b_status.fire && half_delay != 8'd0 |=> !b_status.fire)
    else $error("snapshot hold delay violated");

endmodule
